// ----- hdl/pws_pkg.sv -----
// Package: shared types and constants for the profile weighted separation block.
`timescale 1ns / 1ps

package pws_pkg;

    localparam int ACC_W    = 64;
    localparam int CNT_W    = 7;
    localparam int LEFT_W   = 15;
    localparam int RIGHT_W  = 16;
    localparam int DENOM_W  = 16;
    localparam int OUT_W    = 16;
    localparam int SEP_W    = 17;
    localparam int S4_W     = 21;
    localparam int SQ_W     = 41;
    localparam int MUL_LO_W = 32;

    localparam logic [CNT_W-1:0]          FULL_STEPS  = CNT_W'(ACC_W);
    localparam logic [LEFT_W-1:0]         GAP_LEFT    = 15'h7FFF;
    localparam logic signed [RIGHT_W-1:0] GAP_RIGHT   = -16'sd32767;
    localparam logic [DENOM_W-1:0]        DENOM_RESET = 16'd320;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
        logic [ACC_W-1:0] num;
        logic [ACC_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quot;
        logic [ACC_W-1:0] rem;
    } t_div_rsp;

endpackage

// ----- hdl/pws_div.sv -----
// Shared serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pws_div import pws_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_q;
    logic [ACC_W-1:0] r_rem;
    logic [ACC_W-1:0] r_den;

    logic [ACC_W:0]   trial;
    logic [ACC_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_q[ACC_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num << (FULL_STEPS - i_req.steps);
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_q   <= {r_q[ACC_W-2:0], ge};
            r_rem <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == CNT_W'(1));
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- hdl/profile_weighted_separation.sv -----
// Top level: row sequencer, accumulators and output register for weighted separation.
//
// Rows of a glyph pair enter on the in channel (i_in_valid / o_in_ready), one
// transaction per row. The mean leaves on the out channel (o_out_valid /
// i_out_ready) after the row flagged last. The denominator register is written
// on the cfg channel (i_cfg_valid / o_cfg_ready), always ready.
// A counted row's length is set by the serial weight division, one quotient bit
// per cycle in the shared divider. A gap row skips the division and the sums.
// The last row adds the mean division on the same divider, which is skipped
// when no weight was accumulated.
// One row is worked on at a time; o_in_ready is high only between rows.
// Reset clears the sums, the state and the output valid, and sets the
// denominator to 320. A stalled receiver holds the result in the output
// register; the next row is still accepted and processed, and the block
// waits only when a further result is due.
`timescale 1ns / 1ps

module profile_weighted_separation import pws_pkg::*; #(
    parameter int WEIGHT_FRAC_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [LEFT_W-1:0]         i_right_glyph_left_edge,
    input  logic signed [RIGHT_W-1:0] i_left_glyph_right_edge,
    input  logic                      i_last_row,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [OUT_W-1:0]          o_separation,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [DENOM_W-1:0]        i_cfg_denom_q4
);

    localparam int ONE_POS = WEIGHT_FRAC_BITS + 8;
    localparam int NUM_W   = ((ONE_POS > SQ_W - 1) ? ONE_POS : SQ_W - 1) + 1;
    localparam int HI_W    = NUM_W - MUL_LO_W;
    localparam int PROD_W  = NUM_W + SEP_W;
    localparam int PROD_X  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_WDIV  = 4'd3;
    localparam logic [3:0] S_WWAIT = 4'd4;
    localparam logic [3:0] S_MULLO = 4'd5;
    localparam logic [3:0] S_MULHI = 4'd6;
    localparam logic [3:0] S_ADDHI = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_MDIV  = 4'd9;
    localparam logic [3:0] S_MWAIT = 4'd10;
    localparam logic [3:0] S_ROUND = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic [DENOM_W-1:0]        r_denom;
    logic [ACC_W-1:0]          r_wss;
    logic [ACC_W-1:0]          r_ws;
    logic [LEFT_W-1:0]         r_left;
    logic signed [RIGHT_W-1:0] r_right;
    logic                      r_last;
    logic [SEP_W-1:0]          r_sep;
    logic [S4_W-1:0]           r_s4;
    logic [SQ_W-1:0]           r_sq;
    logic [PROD_X-1:0]         r_prod;
    logic [HI_W+SEP_W-1:0]     r_phi;
    logic [OUT_W-1:0]          r_res;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_sep;

    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    logic signed [RIGHT_W+1:0] sdiff;
    logic [SEP_W-1:0]          sep_c;
    logic                      gap_c;
    logic [DENOM_W-1:0]        d_c;
    logic [S4_W-1:0]           s4_c;
    logic [2*S4_W-1:0]         sq_c;
    logic [ACC_W-1:0]          num_c;
    logic [MUL_LO_W+SEP_W-1:0] p_lo_c;
    logic [HI_W+SEP_W-1:0]     p_hi_c;
    logic [ACC_W-1:0]          prod_sat;
    logic [ACC_W:0]            wss_sum;
    logic [ACC_W:0]            ws_sum;
    logic [ACC_W:0]            two_r;
    logic                      up_c;
    logic [OUT_W-1:0]          res_c;
    logic                      in_acc;
    logic                      out_free;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_separation = r_out_sep;

    // row arithmetic
    assign sdiff = $signed({3'b000, r_left}) - $signed({{2{r_right[RIGHT_W-1]}}, r_right});
    assign sep_c = sdiff[RIGHT_W+1] ? '0 : sdiff[SEP_W-1:0];
    assign gap_c = (r_left == GAP_LEFT) || (r_right <= GAP_RIGHT);
    assign d_c   = (r_denom == '0) ? DENOM_W'(1) : r_denom;
    assign s4_c  = {sep_c, 4'b0000} + S4_W'(d_c);
    assign sq_c  = r_s4 * r_s4;
    assign num_c = (ACC_W'(1) << ONE_POS) + ACC_W'(r_sq >> 1);

    assign p_lo_c = div_rsp.quot[MUL_LO_W-1:0] * r_sep;
    assign p_hi_c = div_rsp.quot[NUM_W-1:MUL_LO_W] * r_sep;

    assign prod_sat = (|r_prod[PROD_X-1:ACC_W]) ? '1 : r_prod[ACC_W-1:0];
    assign wss_sum  = {1'b0, r_wss} + {1'b0, prod_sat};
    assign ws_sum   = {1'b0, r_ws} + {1'b0, div_rsp.quot};

    // round half to even, clamp to 16 bits
    assign two_r = {div_rsp.rem, 1'b0};
    assign up_c  = (two_r > {1'b0, r_ws}) || ((two_r == {1'b0, r_ws}) && div_rsp.quot[0]);
    assign res_c = ((|div_rsp.quot[ACC_W-1:OUT_W])
                   || ((div_rsp.quot[OUT_W-1:0] == '1) && up_c))
                 ? '1 : (div_rsp.quot[OUT_W-1:0] + OUT_W'(up_c));

    always_comb begin
        div_req.start = (r_state == S_WDIV) || ((r_state == S_MDIV) && (r_ws != '0));
        if (r_state == S_MDIV) begin
            div_req.steps = FULL_STEPS;
            div_req.num   = r_wss;
            div_req.den   = r_ws;
        end else begin
            div_req.steps = CNT_W'(NUM_W);
            div_req.num   = num_c;
            div_req.den   = ACC_W'(r_sq);
        end
    end

    pws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (!gap_c) begin
                    n_state = S_SQ;
                end else if (r_last) begin
                    n_state = S_MDIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SQ:    n_state = S_WDIV;
            S_WDIV:  n_state = S_WWAIT;
            S_WWAIT: begin
                if (div_rsp.done) begin
                    n_state = S_MULLO;
                end
            end
            S_MULLO: n_state = S_MULHI;
            S_MULHI: n_state = S_ADDHI;
            S_ADDHI: n_state = S_ACC;
            S_ACC:   n_state = r_last ? S_MDIV : S_IDLE;
            S_MDIV:  n_state = (r_ws == '0) ? S_OUT : S_MWAIT;
            S_MWAIT: begin
                if (div_rsp.done) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_denom     <= DENOM_RESET;
            r_wss       <= '0;
            r_ws        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_denom <= i_cfg_denom_q4;
            end
            if (r_state == S_ACC) begin
                r_wss <= wss_sum[ACC_W] ? '1 : wss_sum[ACC_W-1:0];
                r_ws  <= ws_sum[ACC_W] ? '1 : ws_sum[ACC_W-1:0];
            end
            if ((r_state == S_OUT) && out_free) begin
                r_wss       <= '0;
                r_ws        <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_left  <= i_right_glyph_left_edge;
            r_right <= i_left_glyph_right_edge;
            r_last  <= i_last_row;
        end
        if (r_state == S_PREP) begin
            r_sep <= sep_c;
            r_s4  <= s4_c;
        end
        if (r_state == S_SQ) begin
            r_sq <= sq_c[SQ_W-1:0];
        end
        if (r_state == S_MULLO) begin
            r_prod <= PROD_X'(p_lo_c);
        end
        if (r_state == S_MULHI) begin
            r_phi <= p_hi_c;
        end
        if (r_state == S_ADDHI) begin
            r_prod <= r_prod + (PROD_X'(r_phi) << MUL_LO_W);
        end
        if (r_state == S_MDIV) begin
            r_res <= '0;
        end
        if (r_state == S_ROUND) begin
            r_res <= res_c;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out_sep <= r_res;
        end
    end

endmodule
